>>> rtl/nip_pkg.sv
// Shared types, constants and helpers for the NEC infrared pulse decoder.
`default_nettype none

package nip_pkg;

  // Field and register widths
  localparam int DUR_W   = 16;
  localparam int REG_W   = 16;
  localparam int CMD_W   = 16;
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 3;
  localparam int NUM_REG = 8;
  localparam int NUM_REF = 6;

  // Register indexes on the configuration port; the first six are pulse references
  localparam logic [IDX_W-1:0] REG_HDR_MARK  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HDR_SPACE = 3'd1;
  localparam logic [IDX_W-1:0] REG_RPT_SPACE = 3'd2;
  localparam logic [IDX_W-1:0] REG_BIT_MARK  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ONE_SPACE = 3'd4;
  localparam logic [IDX_W-1:0] REG_ZERO_SPACE = 3'd5;
  localparam logic [IDX_W-1:0] REG_ABS_TOL   = 3'd6;
  localparam logic [IDX_W-1:0] REG_EXP_ADDR  = 3'd7;

  // Register reset values
  localparam logic [REG_W-1:0] RST_HDR_MARK   = 16'd1699;
  localparam logic [REG_W-1:0] RST_HDR_SPACE  = 16'd833;
  localparam logic [REG_W-1:0] RST_RPT_SPACE  = 16'd411;
  localparam logic [REG_W-1:0] RST_BIT_MARK   = 16'd115;
  localparam logic [REG_W-1:0] RST_ONE_SPACE  = 16'd306;
  localparam logic [REG_W-1:0] RST_ZERO_SPACE = 16'd95;
  localparam logic [REG_W-1:0] RST_ABS_TOL    = 16'd100;
  localparam logic [REG_W-1:0] RST_EXP_ADDR   = 16'hc03f;

  // Bit counts at the address check and at the end of a frame
  localparam logic [CNT_W-1:0] ADDR_BITS  = 6'd16;
  localparam logic [CNT_W-1:0] FRAME_BITS = 6'd32;

  // Default depth of the queue between classifier and state machine
  localparam int QUEUE_DEPTH_DEF = 4;

  // Pulse classification, each flag already qualified by the pulse level
  typedef struct packed {
    logic hdr_mark;
    logic hdr_space;
    logic rpt_space;
    logic bit_mark;
    logic one_space;
    logic zero_space;
  } pulse_class_t;

  // Frame decoder phases, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_DATA_HI = 4'b0100,
    PH_DATA_LO = 4'b1000
  } phase_t;

  // Absolute difference of two pulse lengths
  function automatic logic [DUR_W-1:0] abs_diff(input logic [DUR_W-1:0] a,
                                                input logic [DUR_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // diff <= tol and diff <= floor(ref/3); the latter is the same as 3*diff <= ref
  function automatic logic pulse_match(input logic [DUR_W-1:0] diff,
                                       input logic [REG_W-1:0] ref_len,
                                       input logic [REG_W-1:0] tol);
    logic [DUR_W+1:0] diff3;
    diff3 = {1'b0, diff, 1'b0} + {2'b00, diff};
    pulse_match = (diff <= tol) && (diff3 <= {2'b00, ref_len});
  endfunction

endpackage

`default_nettype wire

>>> rtl/nip_front.sv
// Front end: configuration registers, pulse length compare and classification.
`default_nettype none

module nip_front import nip_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // Pulse stream
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [DUR_W-1:0]   s_tdata,   // [15:0] duration
  input  wire logic               s_tuser,   // [0] level
  // Configuration writes
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [REG_W-1:0]   cfg_data,
  // Classified pulses toward the queue
  output logic                    push_valid,
  input  wire logic               push_ready,
  output pulse_class_t            push_class,
  output logic [REG_W-1:0]        expected_address
);

  logic [REG_W-1:0] cfg_reg [NUM_REG];
  logic             s1_valid;
  logic             s1_level;
  logic [DUR_W-1:0] s1_diff [NUM_REF];
  logic             s1_ready;
  logic [REG_W-1:0] tol;

  // Hold configuration registers; write one per transfer on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg[REG_HDR_MARK]   <= RST_HDR_MARK;
      cfg_reg[REG_HDR_SPACE]  <= RST_HDR_SPACE;
      cfg_reg[REG_RPT_SPACE]  <= RST_RPT_SPACE;
      cfg_reg[REG_BIT_MARK]   <= RST_BIT_MARK;
      cfg_reg[REG_ONE_SPACE]  <= RST_ONE_SPACE;
      cfg_reg[REG_ZERO_SPACE] <= RST_ZERO_SPACE;
      cfg_reg[REG_ABS_TOL]    <= RST_ABS_TOL;
      cfg_reg[REG_EXP_ADDR]   <= RST_EXP_ADDR;
    end else if (cfg_we) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  assign tol              = cfg_reg[REG_ABS_TOL];
  assign expected_address = cfg_reg[REG_EXP_ADDR];

  // Advance the difference stage when it is empty or its contents move on
  assign s1_ready = !s1_valid || push_ready;
  assign s_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  // Register the distance of the pulse from every reference
  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      s1_level <= s_tuser;
      for (int i = 0; i < NUM_REF; i++) begin
        s1_diff[i] <= abs_diff(s_tdata, cfg_reg[i]);
      end
    end
  end

  // Classify against tolerance and a third of each reference
  always_comb begin
    push_class.hdr_mark   = s1_level &&
      pulse_match(s1_diff[REG_HDR_MARK], cfg_reg[REG_HDR_MARK], tol);
    push_class.hdr_space  = !s1_level &&
      pulse_match(s1_diff[REG_HDR_SPACE], cfg_reg[REG_HDR_SPACE], tol);
    push_class.rpt_space  = !s1_level &&
      pulse_match(s1_diff[REG_RPT_SPACE], cfg_reg[REG_RPT_SPACE], tol);
    push_class.bit_mark   = s1_level &&
      pulse_match(s1_diff[REG_BIT_MARK], cfg_reg[REG_BIT_MARK], tol);
    push_class.one_space  = !s1_level &&
      pulse_match(s1_diff[REG_ONE_SPACE], cfg_reg[REG_ONE_SPACE], tol);
    push_class.zero_space = !s1_level &&
      pulse_match(s1_diff[REG_ZERO_SPACE], cfg_reg[REG_ZERO_SPACE], tol);
  end

  assign push_valid = s1_valid;

endmodule

`default_nettype wire

>>> rtl/nip_queue.sv
// Short queue of classified pulses between the front end and the frame decoder.
`default_nettype none

module nip_queue import nip_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire pulse_class_t push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output pulse_class_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  pulse_class_t      mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/nip_back.sv
// Back end: NEC frame state machine, bit shifter and result register.
`default_nettype none

module nip_back import nip_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire pulse_class_t     pop_class,
  input  wire logic [REG_W-1:0] expected_address,
  // Result stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [CMD_W-1:0]      m_tdata,   // [15:0] command
  output logic                  m_tuser    // [0] is_repeat
);

  phase_t           phase;
  phase_t           phase_next;
  logic [CNT_W-1:0] bit_count;
  logic [CNT_W-1:0] bit_count_next;
  logic [CMD_W-1:0] shift_word;
  logic [CMD_W-1:0] shift_word_next;
  logic [CNT_W-1:0] cnt_inc;
  logic [CMD_W-1:0] shifted;
  logic             emit;
  logic             emit_rpt;
  logic [CMD_W-1:0] emit_cmd;
  logic             do_pop;

  // Take a pulse whenever the result register can take what it may cause
  assign pop_ready = !m_tvalid || m_tready;
  assign do_pop    = pop_valid && pop_ready;

  assign cnt_inc = bit_count + 1'b1;
  assign shifted = {shift_word[CMD_W-2:0], pop_class.one_space};

  // Step the frame decoder for one pulse
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    emit            = 1'b0;
    emit_rpt        = 1'b0;
    emit_cmd        = shift_word;
    unique case (phase)
      PH_IDLE: begin
        if (pop_class.hdr_mark) begin
          phase_next = PH_HEADER;
        end else begin
          bit_count_next = '0;
        end
      end
      PH_HEADER: begin
        if (pop_class.rpt_space) begin
          // Repeat frame: re-send whatever the shifter holds
          emit           = 1'b1;
          emit_rpt       = 1'b1;
          phase_next     = PH_IDLE;
          bit_count_next = '0;
        end else if (pop_class.hdr_space) begin
          phase_next      = PH_DATA_HI;
          shift_word_next = '0;
        end else begin
          phase_next     = PH_IDLE;
          bit_count_next = '0;
        end
      end
      PH_DATA_HI: begin
        if (pop_class.bit_mark) begin
          phase_next = PH_DATA_LO;
        end else begin
          phase_next     = PH_IDLE;
          bit_count_next = '0;
        end
      end
      PH_DATA_LO: begin
        if (pop_class.one_space || pop_class.zero_space) begin
          bit_count_next  = cnt_inc;
          shift_word_next = shifted;
          phase_next      = PH_DATA_HI;
          if (cnt_inc == ADDR_BITS) begin
            // Address check: drop the frame or clear for the command half
            if (shifted != expected_address) begin
              phase_next     = PH_IDLE;
              bit_count_next = '0;
            end else begin
              shift_word_next = '0;
            end
          end else if (cnt_inc == FRAME_BITS) begin
            emit           = 1'b1;
            emit_cmd       = shifted;
            phase_next     = PH_IDLE;
            bit_count_next = '0;
          end
        end else begin
          phase_next     = PH_IDLE;
          bit_count_next = '0;
        end
      end
      default: begin
        phase_next     = PH_IDLE;
        bit_count_next = '0;
      end
    endcase
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_word <= '0;
    end else if (do_pop) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
    end
  end

  // Result register: load on a result, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_pop && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && emit) begin
      m_tdata <= emit_cmd;
      m_tuser <= emit_rpt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nec_ir_pulse_decoder.sv
// NEC infrared pulse decoder: classifies pulses, decodes frames, emits commands.
// A result passes the compare stage, the queue and the result register onto m_tvalid.
// Throughput: one pulse per cycle; the queue and result register let either side stall.
// The state machine step (one pulse per cycle) and the compare stage set the rate.
// Reset (rst, synchronous): registers take their defaults, decoder idles, queue empties.
`default_nettype none

module nec_ir_pulse_decoder import nip_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Pulse stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [DUR_W-1:0] s_tdata,   // [15:0] duration
  input  wire logic             s_tuser,   // [0] level
  // Result stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [CMD_W-1:0]      m_tdata,   // [15:0] command
  output logic                  m_tuser,   // [0] is_repeat
  // Configuration writes
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);

  logic             push_valid;
  logic             push_ready;
  pulse_class_t     push_class;
  logic             pop_valid;
  logic             pop_ready;
  pulse_class_t     pop_class;
  logic [REG_W-1:0] expected_address;

  nip_front u_front (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_class       (push_class),
    .expected_address (expected_address)
  );

  nip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_class),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_class)
  );

  nip_back u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_class        (pop_class),
    .expected_address (expected_address),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser)
  );

endmodule

`default_nettype wire

>>> tb/sv/nec_ir_pulse_checker.sv
// Checker for the NEC pulse decoder: tracks registers, predicts commands, compares results.
`timescale 1ns / 100ps

module nec_ir_pulse_checker import nip_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [DUR_W-1:0] s_tdata,   // [15:0] duration
  input  logic             s_tuser,   // [0] level
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [CMD_W-1:0] m_tdata,   // [15:0] command
  input  logic             m_tuser,   // [0] is_repeat
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output int               fail_count,
  output int               cmds_due,
  output int               cmds_seen,
  output int               repeats_seen
);

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             is_repeat;
  } ir_cmd_t;

  // Register copy and decoder state as the block should hold them
  logic [REG_W-1:0] ref_len [NUM_REG];
  phase_t           dec_phase;
  logic [CNT_W-1:0] bit_cnt;
  logic [CMD_W-1:0] rx_word;
  ir_cmd_t          cmd_fifo [$];

  // A pulse fits when its deviation is within the tolerance and within a third of the length
  function automatic bit pulse_fits(input logic [REG_W-1:0] ref_v,
                                    input logic [DUR_W-1:0] dur);
    int dev;
    dev = (dur >= ref_v) ? int'(dur) - int'(ref_v) : int'(ref_v) - int'(dur);
    return (dev <= int'(ref_len[REG_ABS_TOL])) && (dev <= int'(ref_v) / 3);
  endfunction

  task automatic drop_frame();
    dec_phase = PH_IDLE;
    bit_cnt   = '0;
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] word, input logic rpt);
    ir_cmd_t entry;
    entry.command   = word;
    entry.is_repeat = rpt;
    cmd_fifo.push_back(entry);
  endtask

  // Advance the frame decoder by one pulse
  task automatic decode_pulse(input logic mark, input logic [DUR_W-1:0] dur);
    logic is_one;
    logic is_zero;
    is_one  = !mark && pulse_fits(ref_len[REG_ONE_SPACE], dur);
    is_zero = !mark && pulse_fits(ref_len[REG_ZERO_SPACE], dur);
    case (dec_phase)
      PH_IDLE: begin
        if (mark && pulse_fits(ref_len[REG_HDR_MARK], dur)) dec_phase = PH_HEADER;
        else drop_frame();
      end
      PH_HEADER: begin
        // Repeat space wins when both spaces fit
        if (!mark && pulse_fits(ref_len[REG_RPT_SPACE], dur)) begin
          queue_cmd(rx_word, 1'b1);
          drop_frame();
        end else if (!mark && pulse_fits(ref_len[REG_HDR_SPACE], dur)) begin
          dec_phase = PH_DATA_HI;
          rx_word   = '0;
        end else begin
          drop_frame();
        end
      end
      PH_DATA_HI: begin
        if (mark && pulse_fits(ref_len[REG_BIT_MARK], dur)) dec_phase = PH_DATA_LO;
        else drop_frame();
      end
      default: begin
        if (!is_one && !is_zero) begin
          drop_frame();
        end else begin
          // One space wins when both fit
          bit_cnt   = bit_cnt + 1'b1;
          rx_word   = {rx_word[CMD_W-2:0], is_one};
          dec_phase = PH_DATA_HI;
          if (bit_cnt == ADDR_BITS) begin
            if (rx_word != ref_len[REG_EXP_ADDR]) drop_frame();
            else rx_word = '0;
          end else if (bit_cnt == FRAME_BITS) begin
            queue_cmd(rx_word, 1'b0);
            drop_frame();
          end
        end
      end
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Watch both streams and the register port at each rising edge
  always @(posedge clk) begin
    ir_cmd_t want;
    if (rst) begin
      ref_len[REG_HDR_MARK]   = RST_HDR_MARK;
      ref_len[REG_HDR_SPACE]  = RST_HDR_SPACE;
      ref_len[REG_RPT_SPACE]  = RST_RPT_SPACE;
      ref_len[REG_BIT_MARK]   = RST_BIT_MARK;
      ref_len[REG_ONE_SPACE]  = RST_ONE_SPACE;
      ref_len[REG_ZERO_SPACE] = RST_ZERO_SPACE;
      ref_len[REG_ABS_TOL]    = RST_ABS_TOL;
      ref_len[REG_EXP_ADDR]   = RST_EXP_ADDR;
      dec_phase    = PH_IDLE;
      bit_cnt      = '0;
      rx_word      = '0;
      cmd_fifo.delete();
      fail_count   = 0;
      cmds_due     = 0;
      cmds_seen    = 0;
      repeats_seen = 0;
    end else begin
      if (cfg_we) ref_len[cfg_index] = cfg_data;
      // Check each result transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (cmd_fifo.size() == 0) begin
          note_failure($sformatf("unexpected result: command %h repeat %b",
                                 m_tdata, m_tuser));
        end else begin
          want = cmd_fifo.pop_front();
          cmds_seen++;
          if (want.is_repeat) repeats_seen++;
          if (want.command !== m_tdata || want.is_repeat !== m_tuser)
            note_failure($sformatf("mismatch: command exp %h got %h, repeat exp %b got %b",
                                   want.command, m_tdata, want.is_repeat, m_tuser));
        end
      end
      if (s_tvalid && s_tready) decode_pulse(s_tuser, s_tdata);
      cmds_due = cmd_fifo.size();
    end
  end

endmodule

>>> tb/sv/nec_ir_pulse_decoder_test.sv
// Testbench top for the NEC pulse decoder: clock, reset, pulse stimulus and verdict.
`timescale 1ns / 100ps

module nec_ir_pulse_decoder_test;
  import nip_pkg::*;

  localparam int FRAME_PULSES = 66;    // header mark and space plus 32 mark/space pairs
  localparam int NUM_SETTINGS = 7;
  localparam int SETTING_LEN  = 235;   // pulses per register setting
  localparam int SETTLE_CYC   = 20;
  localparam int QUIET_LIMIT  = 2000;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [DUR_W-1:0] s_tdata;   // [15:0] duration
  logic             s_tuser;   // [0] level
  logic             m_tvalid;
  logic             m_tready;
  logic [CMD_W-1:0] m_tdata;   // [15:0] command
  logic             m_tuser;   // [0] is_repeat
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  int fail_count;
  int cmds_due;
  int cmds_seen;
  int repeats_seen;
  int pulses_sent;
  int quiet_cycles;
  bit gaps_on;

  // Register values as last written, used to shape the pulses
  logic [REG_W-1:0] reg_set [NUM_REG];

  nec_ir_pulse_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nec_ir_pulse_checker cmd_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .cmds_due     (cmds_due),
    .cmds_seen    (cmds_seen),
    .repeats_seen (repeats_seen)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Stall the result side at random while gaps are enabled
  always @(negedge clk) m_tready = !gaps_on || ($urandom_range(99) >= 17);

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // A length inside the match window of r, often right at its edges
  function automatic logic [DUR_W-1:0] jitter(input logic [REG_W-1:0] r);
    int span;
    int dev;
    int len;
    span = int'(r) / 3;
    if (int'(reg_set[REG_ABS_TOL]) < span) span = int'(reg_set[REG_ABS_TOL]);
    case ($urandom_range(9))
      0:       dev = span;
      1:       dev = -span;
      default: dev = int'($urandom_range(2 * span)) - span;
    endcase
    len = int'(r) + dev;
    if (len < 0) len = 0;
    else if (len > 65535) len = 65535;
    return DUR_W'(len);
  endfunction

  // Offer one pulse, hold it until the transfer, then drop valid
  task automatic push_pulse(input logic mark, input logic [DUR_W-1:0] dur);
    while (gaps_on && $urandom_range(99) < 17) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = mark;
    s_tdata  = dur;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pulses_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Either a full-range random pulse or one close to some reference
  task automatic send_noise();
    logic [DUR_W-1:0] dur;
    dur = $urandom_range(1) ? DUR_W'($urandom)
                            : jitter(reg_set[IDX_W'($urandom_range(NUM_REF - 1))]);
    push_pulse(1'($urandom_range(1)), dur);
  endtask

  task automatic send_repeat();
    push_pulse(1'b1, jitter(reg_set[REG_HDR_MARK]));
    push_pulse(1'b0, jitter(reg_set[REG_RPT_SPACE]));
  endtask

  // Send the first cut pulses of a frame; a cut frame ends with a pulse of the wrong level
  task automatic send_frame(input logic [CMD_W-1:0] addr, input logic [CMD_W-1:0] cmd,
                            input int cut, input int noise_pct);
    logic [31:0]      word;
    logic [REG_W-1:0] r;
    word = {addr, cmd};
    for (int p = 0; p < cut; p++) begin
      if (p == 0) r = reg_set[REG_HDR_MARK];
      else if (p == 1) r = reg_set[REG_HDR_SPACE];
      else if (p % 2 == 0) r = reg_set[REG_BIT_MARK];
      else r = word[31 - (p - 3) / 2] ? reg_set[REG_ONE_SPACE] : reg_set[REG_ZERO_SPACE];
      if ($urandom_range(99) < noise_pct) send_noise();
      else push_pulse(p % 2 == 0, jitter(r));
    end
    if (cut < FRAME_PULSES) push_pulse(cut % 2 != 0, DUR_W'($urandom));
  endtask

  function automatic logic [CMD_W-1:0] pick_addr();
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) return reg_set[REG_EXP_ADDR];
    if (pick < 93) return reg_set[REG_EXP_ADDR] ^ (CMD_W'(1) << $urandom_range(CMD_W - 1));
    return CMD_W'($urandom);
  endfunction

  // One random sequence: mostly well-formed frames and repeats, some broken ones and noise
  task automatic run_episode();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_frame(pick_addr(), CMD_W'($urandom), FRAME_PULSES,
                 ($urandom_range(99) < 30) ? 2 : 0);
    end else if (pick < 75) begin
      send_repeat();
    end else if (pick < 88) begin
      send_frame(pick_addr(), CMD_W'($urandom), $urandom_range(1, FRAME_PULSES - 1), 0);
      send_repeat();
    end else begin
      repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we       = 1'b1;
    cfg_index    = idx;
    cfg_data     = val;
    reg_set[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait for all predicted commands, then let pulses without a result drain
  task automatic settle();
    while (cmds_due != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Write all registers for one setting; anything not listed keeps its reset value
  task automatic load_setting(input int which);
    logic [REG_W-1:0] v [NUM_REG];
    v[REG_HDR_MARK]   = RST_HDR_MARK;
    v[REG_HDR_SPACE]  = RST_HDR_SPACE;
    v[REG_RPT_SPACE]  = RST_RPT_SPACE;
    v[REG_BIT_MARK]   = RST_BIT_MARK;
    v[REG_ONE_SPACE]  = RST_ONE_SPACE;
    v[REG_ZERO_SPACE] = RST_ZERO_SPACE;
    v[REG_ABS_TOL]    = RST_ABS_TOL;
    v[REG_EXP_ADDR]   = RST_EXP_ADDR;
    case (which)
      // zero tolerance: only exact lengths match
      1: begin
        v[REG_ABS_TOL]  = '0;
        v[REG_EXP_ADDR] = REG_W'($urandom);
      end
      // lengths near the top of the range, tolerance at its maximum
      2: begin
        v[REG_HDR_MARK]   = 16'd65535;
        v[REG_HDR_SPACE]  = 16'd60000;
        v[REG_RPT_SPACE]  = 16'd30000;
        v[REG_BIT_MARK]   = 16'd40000;
        v[REG_ONE_SPACE]  = 16'd50000;
        v[REG_ZERO_SPACE] = 16'd20000;
        v[REG_ABS_TOL]    = 16'd65535;
        v[REG_EXP_ADDR]   = REG_W'($urandom);
      end
      // lengths at the bottom, zero-length mark and zero space
      3: begin
        v[REG_HDR_MARK]   = 16'd30;
        v[REG_HDR_SPACE]  = 16'd12;
        v[REG_RPT_SPACE]  = 16'd6;
        v[REG_BIT_MARK]   = 16'd0;
        v[REG_ONE_SPACE]  = 16'd3;
        v[REG_ZERO_SPACE] = 16'd0;
        v[REG_ABS_TOL]    = 16'd1;
        v[REG_EXP_ADDR]   = 16'h0000;
      end
      // overlapping windows for both header spaces and both bit spaces
      4: begin
        v[REG_HDR_SPACE]  = 16'd800;
        v[REG_RPT_SPACE]  = 16'd700;
        v[REG_ONE_SPACE]  = 16'd300;
        v[REG_ZERO_SPACE] = 16'd330;
        v[REG_EXP_ADDR]   = 16'hffff;
      end
      5: begin
        v[REG_HDR_MARK]   = REG_W'($urandom_range(30, 20000));
        v[REG_HDR_SPACE]  = REG_W'($urandom_range(30, 20000));
        v[REG_RPT_SPACE]  = REG_W'($urandom_range(30, 20000));
        v[REG_BIT_MARK]   = REG_W'($urandom_range(30, 20000));
        v[REG_ONE_SPACE]  = REG_W'($urandom_range(30, 20000));
        v[REG_ZERO_SPACE] = REG_W'($urandom_range(30, 20000));
        v[REG_ABS_TOL]    = REG_W'($urandom_range(0, 3000));
        v[REG_EXP_ADDR]   = REG_W'($urandom);
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_REG; i++) write_reg(IDX_W'(i), v[i]);
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    gaps_on      = 1'b1;
    pulses_sent  = 0;
    quiet_cycles = 0;
    reg_set[REG_HDR_MARK]   = RST_HDR_MARK;
    reg_set[REG_HDR_SPACE]  = RST_HDR_SPACE;
    reg_set[REG_RPT_SPACE]  = RST_RPT_SPACE;
    reg_set[REG_BIT_MARK]   = RST_BIT_MARK;
    reg_set[REG_ONE_SPACE]  = RST_ONE_SPACE;
    reg_set[REG_ZERO_SPACE] = RST_ZERO_SPACE;
    reg_set[REG_ABS_TOL]    = RST_ABS_TOL;
    reg_set[REG_EXP_ADDR]   = RST_EXP_ADDR;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed pulses on reset values: extremes, window edges, broken frames
    push_pulse(1'b1, 16'd0);
    push_pulse(1'b0, 16'd0);
    push_pulse(1'b0, 16'd65535);
    push_pulse(1'b1, 16'd65535);
    push_pulse(1'b1, 16'd1699);     // repeat of the cleared word
    push_pulse(1'b0, 16'd411);
    push_pulse(1'b1, 16'd1799);     // both header pulses at the tolerance edge
    push_pulse(1'b0, 16'd733);
    push_pulse(1'b1, 16'd153);      // mark at the third-of-length edge, then a one
    push_pulse(1'b0, 16'd406);
    push_pulse(1'b1, 16'd77);       // then a zero at its lower edge
    push_pulse(1'b0, 16'd64);
    push_pulse(1'b1, 16'd154);      // just outside: frame broken
    push_pulse(1'b1, 16'd1598);     // just outside the header mark
    push_pulse(1'b1, 16'd1599);     // repeat of the partial word
    push_pulse(1'b0, 16'd311);
    push_pulse(1'b1, 16'd1699);     // header followed by a mark
    push_pulse(1'b1, 16'd411);
    push_pulse(1'b1, 16'd1699);     // header space matching neither length
    push_pulse(1'b0, 16'd1000);
    push_pulse(1'b1, 16'd1699);     // mark where a bit space belongs
    push_pulse(1'b0, 16'd833);
    push_pulse(1'b1, 16'd115);
    push_pulse(1'b1, 16'd306);

    // Random frames under each register setting; the setting without gaps runs back to back
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph > 0) begin
        settle();
        load_setting(ph);
      end
      gaps_on = (ph != 3);
      while (pulses_sent < SETTING_LEN * (ph + 1)) run_episode();
    end

    gaps_on = 1'b0;
    while (cmds_due != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    $display("Sent %0d pulses under %0d register settings, edge cases first.",
             pulses_sent, NUM_SETTINGS);
    $display("Checked %0d commands, %0d of them from repeat frames.",
             cmds_seen, repeats_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
